FILE: src/pdmw_pkg.sv
// shared codes, control and status bundles for the per-device median window table
// used by pdmw_ctrl, pdmw_datapath, the top level and the checker
package pdmw_pkg;

    localparam int DEVICES_DEF     = 32;
    localparam int WINDOW_DEF      = 5;
    localparam int MEDIAN_RANK_DEF = 2;

    localparam int MAC_W  = 48;
    localparam int SS_W   = 8;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int RQ_W   = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    localparam logic [RQ_W-1:0] READY_QUARTERS_RST = 3'd3;

    localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd1;
    localparam logic [OP_W-1:0] OP_READY  = 3'd2;
    localparam logic [OP_W-1:0] OP_GC     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFULL = 2'd2;

    typedef struct packed {
        logic              capture;
        logic              idx_clr;
        logic              idx_inc;
        logic              rd;
        logic              upd_hit_wr;
        logic              upd_new_wr;
        logic              med_load;
        logic              cnt_acc;
        logic              latch_eval;
        logic              gc;
        logic              clear;
        logic              load_out;
        logic              out_report;
        logic [STAT_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic hit;
        logic slot_sel;
        logic free_avail;
        logic more_full;
        logic out_free;
        logic latch;
    } stat_t;

endpackage

FILE: src/pdmw_datapath.sv
// datapath: key and window memories, used/full flags, scan index, median, counters
// and the output register; depends on pdmw_pkg
module pdmw_datapath #(
    parameter int DEVICES     = pdmw_pkg::DEVICES_DEF,
    parameter int WINDOW      = pdmw_pkg::WINDOW_DEF,
    parameter int MEDIAN_RANK = pdmw_pkg::MEDIAN_RANK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pdmw_pkg::cmd_t                       cmd,
    output pdmw_pkg::stat_t                      stat,
    input  logic [pdmw_pkg::MAC_W-1:0]           in_mac,
    input  logic [pdmw_pkg::SS_W-1:0]            in_ss,
    input  logic                                 cfg_valid,
    input  logic [pdmw_pkg::RQ_W-1:0]            cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [pdmw_pkg::STAT_W-1:0]          out_status,
    output logic [pdmw_pkg::MAC_W-1:0]           out_mac,
    output logic [pdmw_pkg::SS_W-1:0]            out_med,
    output logic                                 out_rdy,
    output logic                                 out_last
);

    localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int CNT_W = $clog2(DEVICES + 1);
    localparam int WIN_W = WINDOW * pdmw_pkg::SS_W;
    localparam int RANK  = (MEDIAN_RANK >= WINDOW) ? WINDOW - 1 : MEDIAN_RANK;
    localparam int CMP_W = CNT_W + 3;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEVICES - 1);

    logic [pdmw_pkg::MAC_W-1:0] key_mem [DEVICES];
    logic [WIN_W-1:0]           win_mem [DEVICES];

    logic [pdmw_pkg::MAC_W-1:0] mac_reg;
    logic [pdmw_pkg::SS_W-1:0]  ss_reg;
    logic [pdmw_pkg::MAC_W-1:0] key_rd_reg;
    logic [WIN_W-1:0]           win_rd_reg;
    logic [pdmw_pkg::SS_W-1:0]  med_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [DEVICES-1:0]         used_reg;
    logic [DEVICES-1:0]         full_reg;
    logic [CNT_W-1:0]           used_cnt_reg;
    logic [CNT_W-1:0]           full_cnt_reg;
    logic                       latch_reg;
    logic [pdmw_pkg::RQ_W-1:0]  rq_reg;
    logic                       out_valid_reg;
    logic [pdmw_pkg::STAT_W-1:0] out_status_reg;
    logic [pdmw_pkg::MAC_W-1:0] out_mac_reg;
    logic [pdmw_pkg::SS_W-1:0]  out_med_reg;
    logic                       out_rdy_reg;
    logic                       out_last_reg;

    logic [IDX_W-1:0]           free_slot;
    logic [WIN_W+pdmw_pkg::SS_W-1:0] win_cat;
    logic [WIN_W-1:0]           win_shift;
    logic [WIN_W-1:0]           win_new;
    logic [DEVICES-1:0]         sel_vec;
    logic [DEVICES-1:0]         above_vec;
    logic [CMP_W-1:0]           lhs;
    logic [CMP_W-1:0]           rhs;

    function automatic logic [pdmw_pkg::SS_W-1:0] win_median(input logic [WIN_W-1:0] w);
        logic signed [pdmw_pkg::SS_W-1:0] a;
        logic signed [pdmw_pkg::SS_W-1:0] b;
        logic [pdmw_pkg::SS_W-1:0]        res;
        int                               r;
        res = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            a = w[i*pdmw_pkg::SS_W +: pdmw_pkg::SS_W];
            r = 0;
            for (int j = 0; j < WINDOW; j++)
            begin
                b = w[j*pdmw_pkg::SS_W +: pdmw_pkg::SS_W];
                if ((b < a) || ((b == a) && (j < i)))
                    r = r + 1;
            end
            if (r == RANK)
                res = a;
        end
        return res;
    endfunction

    always_comb
    begin
        free_slot = '0;
        for (int i = DEVICES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
                free_slot = IDX_W'(i);
        end
    end

    assign win_cat   = {win_rd_reg, ss_reg};
    assign win_shift = win_cat[WIN_W-1:0];

    always_comb
    begin
        win_new = '0;
        win_new[pdmw_pkg::SS_W-1:0] = ss_reg;
    end

    assign sel_vec   = used_reg & full_reg;
    assign above_vec = (sel_vec >> idx_reg) >> 1;

    assign lhs = CMP_W'({full_cnt_reg, 2'b00});
    assign rhs = CMP_W'(rq_reg) * CMP_W'(used_cnt_reg);

    assign stat.idx_last   = (idx_reg == IDX_LAST);
    assign stat.hit        = used_reg[idx_reg] && (key_rd_reg == mac_reg);
    assign stat.slot_sel   = sel_vec[idx_reg];
    assign stat.free_avail = ~&used_reg;
    assign stat.more_full  = |above_vec;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.latch      = latch_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            key_rd_reg <= key_mem[idx_reg];
            win_rd_reg <= win_mem[idx_reg];
        end
        if (cmd.upd_hit_wr)
            win_mem[idx_reg] <= win_shift;
        if (cmd.upd_new_wr)
        begin
            win_mem[free_slot] <= win_new;
            key_mem[free_slot] <= mac_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mac_reg <= in_mac;
            ss_reg  <= in_ss;
        end
        if (cmd.med_load)
            med_reg <= win_median(win_rd_reg);
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_rdy_reg    <= latch_reg;
            if (cmd.out_report)
            begin
                out_mac_reg  <= key_rd_reg;
                out_med_reg  <= med_reg;
                out_last_reg <= !stat.more_full;
            end
            else
            begin
                out_mac_reg  <= '0;
                out_med_reg  <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            used_reg      <= '0;
            full_reg      <= '0;
            used_cnt_reg  <= '0;
            full_cnt_reg  <= '0;
            latch_reg     <= 1'b0;
            rq_reg        <= pdmw_pkg::READY_QUARTERS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                rq_reg <= cfg_data;
            if (cmd.idx_clr)
            begin
                idx_reg      <= '0;
                used_cnt_reg <= '0;
                full_cnt_reg <= '0;
            end
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.cnt_acc)
            begin
                used_cnt_reg <= used_cnt_reg + CNT_W'(used_reg[idx_reg]);
                full_cnt_reg <= full_cnt_reg + CNT_W'(sel_vec[idx_reg]);
            end
            if (cmd.latch_eval && (lhs >= rhs))
                latch_reg <= 1'b1;
            if (cmd.upd_hit_wr)
                full_reg[idx_reg] <= (win_shift[WIN_W-1 -: pdmw_pkg::SS_W] != '0);
            if (cmd.upd_new_wr)
            begin
                used_reg[free_slot] <= 1'b1;
                full_reg[free_slot] <= (win_new[WIN_W-1 -: pdmw_pkg::SS_W] != '0);
            end
            if (cmd.gc)
                used_reg <= used_reg & full_reg;
            if (cmd.clear)
            begin
                used_reg  <= '0;
                latch_reg <= 1'b0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_mac    = out_mac_reg;
    assign out_med    = out_med_reg;
    assign out_rdy    = out_rdy_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: src/pdmw_ctrl.sv
// controller state machine sequencing updates, reports, ready checks and housekeeping
// depends on pdmw_pkg
module pdmw_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [pdmw_pkg::OP_W-1:0]    in_op,
    output logic                         in_ready,
    input  pdmw_pkg::stat_t              stat,
    output pdmw_pkg::cmd_t               cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_UPD_RD, S_UPD_CHK, S_REP_RD, S_REP_MED, S_REP_OUT,
        S_RDY_CNT, S_RDY_EVAL, S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [pdmw_pkg::STAT_W-1:0] st_reg, st_next;
    logic                        any_reg, any_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        any_next   = any_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.idx_clr = 1'b1;
                    st_next     = pdmw_pkg::ST_DONE;
                    any_next    = 1'b0;
                    case (in_op)
                        pdmw_pkg::OP_UPDATE: state_next = S_UPD_RD;
                        pdmw_pkg::OP_REPORT: state_next = S_REP_RD;
                        pdmw_pkg::OP_READY:
                            state_next = stat.latch ? S_EMIT : S_RDY_CNT;
                        pdmw_pkg::OP_GC:
                        begin
                            cmd.gc     = 1'b1;
                            state_next = S_EMIT;
                        end
                        pdmw_pkg::OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_UPD_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPD_CHK;
            end
            S_UPD_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.upd_hit_wr = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (stat.idx_last)
                begin
                    if (stat.free_avail)
                        cmd.upd_new_wr = 1'b1;
                    else
                        st_next = pdmw_pkg::ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_UPD_RD;
                end
            end
            S_REP_RD:
            begin
                if (stat.slot_sel)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_REP_MED;
                end
                else if (stat.idx_last)
                begin
                    if (any_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        st_next    = pdmw_pkg::ST_NOFULL;
                        state_next = S_EMIT;
                    end
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_REP_MED:
            begin
                cmd.med_load = 1'b1;
                state_next   = S_REP_OUT;
            end
            S_REP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_report = 1'b1;
                    cmd.out_status = pdmw_pkg::ST_DONE;
                    any_next       = 1'b1;
                    if (stat.idx_last || !stat.more_full)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_REP_RD;
                    end
                end
            end
            S_RDY_CNT:
            begin
                cmd.cnt_acc = 1'b1;
                if (stat.idx_last)
                    state_next = S_RDY_EVAL;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_RDY_EVAL:
            begin
                cmd.latch_eval = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= pdmw_pkg::ST_DONE;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            any_reg   <= any_next;
        end
    end

endmodule

FILE: src/per_device_median_window_table_unit.sv
// top level: stream ports around pdmw_ctrl and pdmw_datapath, depends on pdmw_pkg
// update scans the slots until a key matches, else fills the lowest free slot or reports full
// report reads each slot with a full window and sends its median, ending after the last one;
//   no-full status when none is full; ready check counts used and full slots unless latched
// others emit one status result; a new result waits while the previous one is stalled
// reset: table empty, ready latch clear, ready_quarters 3, no result pending
module per_device_median_window_table_unit #(
    parameter int DEVICES     = pdmw_pkg::DEVICES_DEF,
    parameter int WINDOW      = pdmw_pkg::WINDOW_DEF,
    parameter int MEDIAN_RANK = pdmw_pkg::MEDIAN_RANK_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pdmw_pkg::IN_DATA_W-1:0]     s_tdata,   // device_mac, strength
    input  logic [pdmw_pkg::OP_W-1:0]          s_tuser,   // operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdmw_pkg::OUT_DATA_W-1:0]    m_tdata,   // report_mac, median_strength, ready_res
    output logic [pdmw_pkg::STAT_W-1:0]        m_tuser,   // status
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdmw_pkg::RQ_W-1:0]          cfg_data   // ready_quarters
);

    pdmw_pkg::cmd_t             cmd;
    pdmw_pkg::stat_t            stat;
    logic [pdmw_pkg::MAC_W-1:0] out_mac;
    logic [pdmw_pkg::SS_W-1:0]  out_med;
    logic                       out_rdy;

    assign cfg_ready = 1'b1;

    pdmw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdmw_datapath #(
        .DEVICES     (DEVICES),
        .WINDOW      (WINDOW),
        .MEDIAN_RANK (MEDIAN_RANK)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_mac     (s_tdata[pdmw_pkg::MAC_W-1:0]),
        .in_ss      (s_tdata[pdmw_pkg::MAC_W +: pdmw_pkg::SS_W]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_mac    (out_mac),
        .out_med    (out_med),
        .out_rdy    (out_rdy),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0, out_rdy, out_med, out_mac};

endmodule

FILE: src/pdmw_checker.sv
// port-level checker for the per-device median window table, bound to the top level
// depends on pdmw_pkg
module pdmw_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pdmw_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [pdmw_pkg::STAT_W-1:0]        m_tuser,
    input logic                               m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == pdmw_pkg::ST_NOFULL) |-> m_tlast && (m_tdata[55:0] == '0))
        else $error("empty report carries data");

    a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == pdmw_pkg::ST_FULL) |-> m_tlast && (m_tdata[55:0] == '0))
        else $error("dropped sample result malformed");

    a_midrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tuser == pdmw_pkg::ST_DONE))
        else $error("non-final result with error status");

endmodule

bind per_device_median_window_table_unit pdmw_checker u_pdmw_checker (.*);
